@@ hdl/ecwc_pkg.sv @@
// Shared types, constants and the timestamp compare for the event capture window controller.
`timescale 1ns / 1ps

package ecwc_pkg;

    localparam int SEC_W     = 32;
    localparam int NSEC_W    = 30;
    localparam int CFG_W     = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 128;

    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PRE    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_POST   = 2'd2;

    localparam logic [CFG_W-1:0] WINDOW_RESET = 16'd10;
    localparam logic [CFG_W-1:0] PRE_RESET    = 16'd5;
    localparam logic [CFG_W-1:0] POST_RESET   = 16'd5;

    localparam logic KIND_TIME  = 1'b0;
    localparam logic KIND_EVENT = 1'b1;

    typedef struct packed {
        logic [SEC_W-1:0]  sec;
        logic [NSEC_W-1:0] nsec;
    } stamp_t;

    // True when a is strictly earlier than b; seconds compare as signed values.
    function automatic logic earlier(input stamp_t a, input stamp_t b);
        logic sec_lt;
        sec_lt = $signed(a.sec) < $signed(b.sec);
        return sec_lt || ((a.sec == b.sec) && (a.nsec < b.nsec));
    endfunction

endpackage

@@ hdl/event_capture_window_controller.sv @@
// Top level of the event capture window controller.
`timescale 1ns / 1ps
// The input register holds each transfer and the output register its result.
// Throughput: one input transfer per cycle unless a result waits at the output;
// the update is 32-bit adds and a subtract, then compares of input and state stamps.
// Reset: rst_n clears the interval to zero (idle), loads the register defaults and
// empties both the input and the output register.
module event_capture_window_controller (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [ecwc_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [ecwc_pkg::CFG_W-1:0]           cfg_wdata,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // time_seconds [31:0], time_nanoseconds [61:32], zero [63:62]
    input  logic [ecwc_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // kind [0]
    input  logic                                 s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // from_seconds [31:0], from_nanoseconds [61:32], to_seconds [93:62],
    // to_nanoseconds [123:94], zero [127:124]
    output logic [ecwc_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);

    logic [ecwc_pkg::CFG_W-1:0] window_reg;
    logic [ecwc_pkg::CFG_W-1:0] pre_reg;
    logic [ecwc_pkg::CFG_W-1:0] post_reg;

    logic            in_valid_reg;
    logic            in_kind_reg;
    ecwc_pkg::stamp_t in_stamp_reg;

    ecwc_pkg::stamp_t start_reg;
    ecwc_pkg::stamp_t start_next;
    ecwc_pkg::stamp_t stop_reg;
    ecwc_pkg::stamp_t stop_next;

    logic            out_valid_reg;
    logic            out_valid_next;
    ecwc_pkg::stamp_t from_reg;
    ecwc_pkg::stamp_t to_reg;

    ecwc_pkg::stamp_t event_stop;
    ecwc_pkg::stamp_t event_start;
    ecwc_pkg::stamp_t win_bound;
    ecwc_pkg::stamp_t bound;
    logic            active;
    logic            stop_lt_win;
    logic            ts_lt_bound;
    logic            emit;
    logic            advance;
    logic            in_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= ecwc_pkg::WINDOW_RESET;
            pre_reg    <= ecwc_pkg::PRE_RESET;
            post_reg   <= ecwc_pkg::POST_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                ecwc_pkg::REG_WINDOW: window_reg <= cfg_wdata;
                ecwc_pkg::REG_PRE:    pre_reg    <= cfg_wdata;
                ecwc_pkg::REG_POST:   post_reg   <= cfg_wdata;
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        active = ecwc_pkg::earlier(start_reg, stop_reg);

        event_stop.sec   = in_stamp_reg.sec + {16'd0, post_reg};
        event_stop.nsec  = in_stamp_reg.nsec;
        event_start.sec  = in_stamp_reg.sec - {16'd0, pre_reg};
        event_start.nsec = in_stamp_reg.nsec;

        win_bound.sec  = start_reg.sec + {16'd0, window_reg};
        win_bound.nsec = start_reg.nsec;

        // The current time reaches the earlier boundary when it reaches either one.
        stop_lt_win = ecwc_pkg::earlier(stop_reg, win_bound);
        bound       = stop_lt_win ? stop_reg : win_bound;
        ts_lt_bound = stop_lt_win ? ecwc_pkg::earlier(in_stamp_reg, stop_reg)
                                  : ecwc_pkg::earlier(in_stamp_reg, win_bound);

        emit    = in_valid_reg && (in_kind_reg == ecwc_pkg::KIND_TIME) && active
                  && !ts_lt_bound;
        advance = in_valid_reg && (!emit || !out_valid_reg || m_axis_tready);
        s_axis_tready = !in_valid_reg || advance;
        in_take = s_axis_tvalid && s_axis_tready;

        start_next = start_reg;
        stop_next  = stop_reg;
        if (advance)
        begin
            if (in_kind_reg == ecwc_pkg::KIND_EVENT)
            begin
                if (!active)
                begin
                    start_next = event_start;
                    stop_next  = event_stop;
                end
                else if (ecwc_pkg::earlier(stop_reg, event_stop))
                begin
                    stop_next = event_stop;
                end
            end
            else if (emit)
            begin
                start_next = bound;
            end
        end

        out_valid_next = (out_valid_reg && !m_axis_tready) || (advance && emit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            start_reg     <= '0;
            stop_reg      <= '0;
        end
        else
        begin
            in_valid_reg  <= in_take || (in_valid_reg && !advance);
            out_valid_reg <= out_valid_next;
            start_reg     <= start_next;
            stop_reg      <= stop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_kind_reg       <= s_axis_tuser;
            in_stamp_reg.sec  <= s_axis_tdata[31:0];
            in_stamp_reg.nsec <= s_axis_tdata[61:32];
        end
        if (advance && emit)
        begin
            from_reg <= start_reg;
            to_reg   <= bound;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, to_reg.nsec, to_reg.sec, from_reg.nsec, from_reg.sec};

endmodule

@@ hdl/ecwc_checker.sv @@
// Port-level assertions for the event capture window controller, with their bind.
`timescale 1ns / 1ps
module ecwc_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [ecwc_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

    // A result that waits holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("Result changed while stalled.");

    // With the output slot empty, the input side never stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("Input stalled with the output empty.");

    // A taken result always frees room for the next input.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("Input stalled while the output drains.");

    // A new result goes valid only from a transfer that was first held in the input register
    // and then passed on to the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("Result without a matching input transfer.");

endmodule

bind event_capture_window_controller ecwc_checker u_ecwc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
